// File: hdl/ctsup_pkg.sv
// ----------------------------------------------------------------------------
// ctsup_pkg
// Shared types and constants of the CAN transmit supervisor with alarm edge.
// ----------------------------------------------------------------------------
package ctsup_pkg;

    localparam int SENSORS_DEFAULT = 8;

    localparam logic OP_POLL    = 1'b0;
    localparam logic OP_READING = 1'b1;

    localparam int ALERT_BUS_OFF   = 0;
    localparam int ALERT_RECOVERED = 1;
    localparam int ALERT_TX_FAILED = 3;
    localparam int ALERT_TX_OK     = 4;
    localparam int ALERT_RX_DATA   = 5;

    localparam logic [1:0] CFG_FAIL_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_PERIOD  = 2'd1;
    localparam logic [1:0] CFG_PROBE_PERIOD   = 2'd2;
    localparam logic [1:0] CFG_CO2_ALARM      = 2'd3;

    localparam logic [7:0]  RST_FAIL_THRESHOLD = 8'd3;
    localparam logic [15:0] RST_ACTIVE_PERIOD  = 16'd1000;
    localparam logic [15:0] RST_PROBE_PERIOD   = 16'd2000;
    localparam logic [15:0] RST_CO2_ALARM      = 16'd2000;

    localparam logic [5:0] ID_SENSOR  = 6'h30;
    localparam logic [5:0] ID_ALARM   = 6'h31;
    localparam logic [3:0] LEN_SENSOR = 4'd8;
    localparam logic [3:0] LEN_ALARM  = 4'd4;
    localparam logic [7:0] FAIL_MAX   = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        frame_valid;
        logic [5:0]  frame_id;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
        logic        accepted;
        logic        start_recovery;
        logic        restart_controller;
        logic        version_broadcast;
        logic        probing;
        logic        bus_is_off;
        logic        last;
    } t_result;

endpackage

// File: hdl/can_tx_supervisor_with_alarm_edge_unit.sv
// ----------------------------------------------------------------------------
// can_tx_supervisor_with_alarm_edge_unit
// Tracks bus-off, failed transmits and probe mode, paces sensor frames and
// sends CO2 alarm frames raised on a threshold edge.
// ----------------------------------------------------------------------------
// Input words (valid/stall) are either a poll carrying alert bits and a
// millisecond time, or a sensor reading. Each word is held in an input
// register and handled from there, when it updates the supervisor
// state and pushes its result words into a four-entry output queue: one
// result for a reading, one or two for a poll (sensor frame then alarm frame).
// Output words (valid/stall) come from the head of that queue.
// A word passes through the input register and the queue before its first
// result is on the output. One input word is taken per cycle while results
// drain; a poll with two frames yields two words on the single output port.
// A word waits in the input register until the queue has two free entries,
// so a stalled receiver backs up into the input stall once the queue fills.
// Configuration writes take effect at the next edge; the user must make them while idle, the block does not enforce it.
// Reset clears the state, the queue and the alarm flags, and loads the
// register defaults; no word is pending afterwards.
// ----------------------------------------------------------------------------
module can_tx_supervisor_with_alarm_edge_unit #(
    parameter int SENSORS = ctsup_pkg::SENSORS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [5:0]  i_alert_bits,
    input  logic [31:0] i_now_ms,
    input  logic [63:0] i_reading_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_valid,
    output logic [5:0]  o_frame_id,
    output logic [3:0]  o_frame_length,
    output logic [63:0] o_frame_data,
    output logic        o_accepted,
    output logic        o_start_recovery,
    output logic        o_restart_controller,
    output logic        o_version_broadcast,
    output logic        o_probing,
    output logic        o_bus_is_off,
    output logic        o_last
);

    localparam int IW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int SW = 2 ** IW;
    localparam int QD = ctsup_pkg::QUEUE_DEPTH;
    localparam int QA = ctsup_pkg::QUEUE_AW;

    // configuration
    logic [7:0]  r_fail_threshold;
    logic [15:0] r_active_period;
    logic [15:0] r_probe_period;
    logic [15:0] r_co2_alarm;

    // input register
    logic        r_in_valid;
    logic        r_in_opcode;
    logic [5:0]  r_in_alerts;
    logic [31:0] r_in_now;
    logic [63:0] r_in_data;

    // supervisor state
    logic          r_bus_off;
    logic          r_probe;
    logic [7:0]    r_fail_count;
    logic [31:0]   r_last_send;
    logic          r_env_pending;
    logic [63:0]   r_env_frame;
    logic          r_alarm_pending;
    logic [31:0]   r_alarm_frame;
    logic [SW-1:0] r_alarm_active;

    logic          n_bus_off;
    logic          n_probe;
    logic [7:0]    n_fail_count;
    logic [31:0]   n_last_send;
    logic          n_env_pending;
    logic [63:0]   n_env_frame;
    logic          n_alarm_pending;
    logic [31:0]   n_alarm_frame;
    logic [SW-1:0] n_alarm_active;

    // output queue
    ctsup_pkg::t_result r_q [QD];
    logic [QA-1:0]      r_wr_ptr;
    logic [QA-1:0]      r_rd_ptr;
    logic [QA:0]        r_count;

    ctsup_pkg::t_result w_res0;
    ctsup_pkg::t_result w_res1;
    logic               w_two;
    logic               w_adv;
    logic               w_pop;
    logic [QA-1:0]      w_wr_next;

    ctsup_pkg::t_result w_head;

    // scratch of the single pass
    logic [7:0]  w_idx;
    logic [15:0] w_co2;
    logic        w_in_range;
    logic        w_now_alarm;
    logic        w_edge;
    logic        w_ok;
    logic        w_rec;
    logic        w_rst;
    logic        w_ver;
    logic [7:0]  w_fail_inc;
    logic [15:0] w_period;
    logic [31:0] w_elapsed;
    logic        w_due;
    logic        w_send_env;
    logic        w_send_alarm;

    assign w_adv   = r_in_valid && (r_count <= (QA+1)'(QD - 2));
    assign o_stall = r_in_valid && !w_adv;
    assign w_pop   = o_valid && !i_stall;
    assign w_wr_next = r_wr_ptr + QA'(1);

    assign w_idx       = r_in_data[63:56];
    assign w_co2       = r_in_data[23:8];
    assign w_in_range  = {24'd0, w_idx} < 32'(SENSORS);
    assign w_now_alarm = w_co2 >= r_co2_alarm;
    assign w_edge      = w_now_alarm != r_alarm_active[w_idx[IW-1:0]];

    always_comb begin
        n_bus_off       = r_bus_off;
        n_probe         = r_probe;
        n_fail_count    = r_fail_count;
        n_last_send     = r_last_send;
        n_env_pending   = r_env_pending;
        n_env_frame     = r_env_frame;
        n_alarm_pending = r_alarm_pending;
        n_alarm_frame   = r_alarm_frame;
        n_alarm_active  = r_alarm_active;
        w_ok            = 1'b0;
        w_rec           = 1'b0;
        w_rst           = 1'b0;
        w_ver           = 1'b0;
        w_fail_inc      = r_fail_count;
        w_period        = r_active_period;
        w_elapsed       = '0;
        w_due           = 1'b0;
        w_send_env      = 1'b0;
        w_send_alarm    = 1'b0;
        w_res0          = '0;
        w_res1          = '0;
        w_two           = 1'b0;

        if (r_in_opcode == ctsup_pkg::OP_READING) begin
            w_ok = !r_env_pending && w_in_range && !(w_edge && r_alarm_pending);
            if (w_ok) begin
                n_env_frame   = r_in_data;
                n_env_pending = 1'b1;
                if (w_edge) begin
                    n_alarm_active[w_idx[IW-1:0]] = w_now_alarm;
                    n_alarm_frame   = {w_idx, 7'd0, w_now_alarm, w_co2};
                    n_alarm_pending = 1'b1;
                end
            end
            w_res0.accepted   = w_ok;
            w_res0.probing    = r_probe;
            w_res0.bus_is_off = r_bus_off;
            w_res0.last       = 1'b1;
        end else begin
            if (r_in_alerts[ctsup_pkg::ALERT_BUS_OFF]) begin
                n_bus_off = 1'b1;
                w_rec     = 1'b1;
            end
            if (r_in_alerts[ctsup_pkg::ALERT_RECOVERED]) begin
                w_rst        = 1'b1;
                n_bus_off    = 1'b0;
                n_fail_count = '0;
                n_probe      = 1'b1;
            end
            if (r_in_alerts[ctsup_pkg::ALERT_TX_FAILED] && !n_probe) begin
                w_fail_inc = (n_fail_count == ctsup_pkg::FAIL_MAX) ?
                             n_fail_count : n_fail_count + 8'd1;
                n_fail_count = w_fail_inc;
                if (w_fail_inc >= r_fail_threshold) begin
                    n_probe = 1'b1;
                end
            end
            if (r_in_alerts[ctsup_pkg::ALERT_TX_OK]) begin
                if (n_probe) begin
                    n_probe = 1'b0;
                    w_ver   = 1'b1;
                end
                n_fail_count = '0;
            end
            if (r_in_alerts[ctsup_pkg::ALERT_RX_DATA] && n_probe) begin
                n_probe      = 1'b0;
                n_fail_count = '0;
                w_ver        = 1'b1;
            end

            w_period  = n_probe ? r_probe_period : r_active_period;
            w_elapsed = r_in_now - r_last_send;
            w_due     = !n_bus_off && (w_elapsed >= {16'd0, w_period});
            if (w_due) begin
                n_last_send = r_in_now;
            end
            w_send_env   = w_due && r_env_pending;
            w_send_alarm = !n_bus_off && r_alarm_pending;
            if (w_send_env) begin
                n_env_pending = 1'b0;
            end
            if (w_send_alarm) begin
                n_alarm_pending = 1'b0;
            end

            // first result carries the event requests
            w_res0.start_recovery     = w_rec;
            w_res0.restart_controller = w_rst;
            w_res0.version_broadcast  = w_ver;
            w_res0.probing            = n_probe;
            w_res0.bus_is_off         = n_bus_off;
            w_res0.last               = 1'b1;
            w_res1.probing            = n_probe;
            w_res1.bus_is_off         = n_bus_off;
            w_res1.last               = 1'b1;
            w_res1.frame_valid        = 1'b1;
            w_res1.frame_id           = ctsup_pkg::ID_ALARM;
            w_res1.frame_length       = ctsup_pkg::LEN_ALARM;
            w_res1.frame_data         = {r_alarm_frame, 32'd0};

            if (w_send_env) begin
                w_res0.frame_valid  = 1'b1;
                w_res0.frame_id     = ctsup_pkg::ID_SENSOR;
                w_res0.frame_length = ctsup_pkg::LEN_SENSOR;
                w_res0.frame_data   = r_env_frame;
                w_res0.last         = !w_send_alarm;
                w_two               = w_send_alarm;
            end else if (w_send_alarm) begin
                w_res0.frame_valid  = 1'b1;
                w_res0.frame_id     = ctsup_pkg::ID_ALARM;
                w_res0.frame_length = ctsup_pkg::LEN_ALARM;
                w_res0.frame_data   = {r_alarm_frame, 32'd0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_threshold <= ctsup_pkg::RST_FAIL_THRESHOLD;
            r_active_period  <= ctsup_pkg::RST_ACTIVE_PERIOD;
            r_probe_period   <= ctsup_pkg::RST_PROBE_PERIOD;
            r_co2_alarm      <= ctsup_pkg::RST_CO2_ALARM;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ctsup_pkg::CFG_FAIL_THRESHOLD: r_fail_threshold <= i_cfg_data[7:0];
                ctsup_pkg::CFG_ACTIVE_PERIOD:  r_active_period  <= i_cfg_data;
                ctsup_pkg::CFG_PROBE_PERIOD:   r_probe_period   <= i_cfg_data;
                ctsup_pkg::CFG_CO2_ALARM:      r_co2_alarm      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_opcode <= i_opcode;
            r_in_alerts <= i_alert_bits;
            r_in_now    <= i_now_ms;
            r_in_data   <= i_reading_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_off       <= 1'b0;
            r_probe         <= 1'b0;
            r_fail_count    <= '0;
            r_last_send     <= '0;
            r_env_pending   <= 1'b0;
            r_alarm_pending <= 1'b0;
            r_alarm_active  <= '0;
        end else if (w_adv) begin
            r_bus_off       <= n_bus_off;
            r_probe         <= n_probe;
            r_fail_count    <= n_fail_count;
            r_last_send     <= n_last_send;
            r_env_pending   <= n_env_pending;
            r_alarm_pending <= n_alarm_pending;
            r_alarm_active  <= n_alarm_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_env_frame   <= n_env_frame;
            r_alarm_frame <= n_alarm_frame;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q[r_wr_ptr] <= w_res0;
            if (w_two) begin
                r_q[w_wr_next] <= w_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_adv) begin
                r_wr_ptr <= w_two ? w_wr_next + QA'(1) : w_wr_next;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QA'(1);
            end
            r_count <= r_count
                     + (w_adv ? (w_two ? (QA+1)'(2) : (QA+1)'(1)) : '0)
                     - (w_pop ? (QA+1)'(1) : '0);
        end
    end

    assign w_head  = r_q[r_rd_ptr];
    assign o_valid = r_count != '0;

    assign o_frame_valid        = w_head.frame_valid;
    assign o_frame_id           = w_head.frame_id;
    assign o_frame_length       = w_head.frame_length;
    assign o_frame_data         = w_head.frame_data;
    assign o_accepted           = w_head.accepted;
    assign o_start_recovery     = w_head.start_recovery;
    assign o_restart_controller = w_head.restart_controller;
    assign o_version_broadcast  = w_head.version_broadcast;
    assign o_probing            = w_head.probing;
    assign o_bus_is_off         = w_head.bus_is_off;
    assign o_last               = w_head.last;

endmodule
